// File: rtl/iol_pkg.sv
`timescale 1ns / 1ps

package iol_pkg;

    localparam int DATA_W       = 32;
    localparam int ACTION_W     = 4;
    localparam int INDEX_W      = 8;
    localparam int STATUS_W     = 2;
    localparam int COUNT_OUT_W  = 5;
    localparam int DEF_CAPACITY = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD_LAST     = 4'd0,
        ACT_ADD_FIRST    = 4'd1,
        ACT_INSERT_AT    = 4'd2,
        ACT_REMOVE_FIRST = 4'd3,
        ACT_REMOVE_LAST  = 4'd4,
        ACT_REMOVE_AT    = 4'd5,
        ACT_GET_FIRST    = 4'd6,
        ACT_GET_LAST     = 4'd7,
        ACT_GET_AT       = 4'd8
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE
    } t_op;

    // Command broadcast to every cell of the chain. Positions are 0-based and
    // always fit in the width of the index field.
    typedef struct packed {
        t_op                op;
        logic               rd;
        logic [INDEX_W-1:0] pos;
    } t_cmd;

endpackage

// File: rtl/indexed_ordered_list.sv
`timescale 1ns / 1ps
// A result beat is registered and appears in the cycle after its action beat is accepted.
// Throughput: one action per cycle unless the output is stalled; inserts and removals
// shift every cell of the chain together, and reads come off a chained select bus.
// Reset (synchronous, active low) empties the list and clears the result valid;
// cell contents are not cleared and are only ever read once written.
module indexed_ordered_list
    import iol_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [ACTION_W-1:0]      i_action,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [INDEX_W-1:0]       i_index,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [STATUS_W-1:0]      o_status,
    output logic signed [DATA_W-1:0] o_value_out,
    output logic [COUNT_OUT_W-1:0]   o_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                           w_fire;
    t_cmd                           w_cmd;
    t_status                        w_status;
    logic [CNT_W-1:0]               w_cnt_next;
    logic [CNT_W+COUNT_OUT_W-1:0]   w_cnt_ext;
    logic [DATA_W-1:0]              w_data  [CAPACITY];
    logic [DATA_W-1:0]              w_chain [CAPACITY+1];

    logic                           r_out_valid;
    logic [STATUS_W-1:0]            r_status;
    logic [DATA_W-1:0]              r_value_out;
    logic [COUNT_OUT_W-1:0]         r_count;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_fire     = i_in_valid && !o_in_stall;

    iol_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_action (i_action),
        .i_index  (i_index),
        .o_cmd    (w_cmd),
        .o_status (w_status),
        .o_count  (w_cnt_next)
    );

    assign w_chain[CAPACITY] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_data[g];
        end else begin : g_mid
            assign w_left = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_inner
            assign w_right = w_data[g+1];
        end

        iol_cell #(
            .CELL_POS (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_cmd),
            .i_value    (i_value),
            .i_left     (w_left),
            .i_right    (w_right),
            .i_rd_chain (w_chain[g+1]),
            .o_data     (w_data[g]),
            .o_rd_chain (w_chain[g])
        );
    end

    assign w_cnt_ext = (CNT_W + COUNT_OUT_W)'(w_cnt_next);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status    <= w_status;
            r_value_out <= w_chain[0];
            r_count     <= w_cnt_ext[COUNT_OUT_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_value_out = r_value_out;
    assign o_count     = r_count;

endmodule

// File: rtl/iol_cell.sv
`timescale 1ns / 1ps

module iol_cell
    import iol_pkg::*;
#(
    parameter int CELL_POS = 0
) (
    input  logic              i_clk,
    input  t_cmd              i_cmd,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    input  logic [DATA_W-1:0] i_rd_chain,
    output logic [DATA_W-1:0] o_data,
    output logic [DATA_W-1:0] o_rd_chain
);

    localparam logic [INDEX_W-1:0] MY_POS = INDEX_W'(CELL_POS);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              w_hit;
    logic              w_after;

    assign w_hit   = (i_cmd.pos == MY_POS);
    assign w_after = (MY_POS > i_cmd.pos);

    always_comb begin
        n_data = r_data;
        unique case (i_cmd.op)
            OP_INSERT: begin
                if (w_hit) begin
                    n_data = i_value;
                end else if (w_after) begin
                    n_data = i_left;
                end
            end
            OP_REMOVE: begin
                if (w_hit || w_after) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // The selected cell drops its value onto the read chain; all others pass it on.
    assign o_rd_chain = i_rd_chain | ((i_cmd.rd && w_hit) ? r_data : '0);
    assign o_data     = r_data;

endmodule

// File: rtl/iol_ctrl.sv
`timescale 1ns / 1ps

module iol_ctrl
    import iol_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fire,
    input  logic [ACTION_W-1:0]                 i_action,
    input  logic [INDEX_W-1:0]                  i_index,
    output t_cmd                                o_cmd,
    output t_status                             o_status,
    output logic [$clog2(CAPACITY+1)-1:0]       o_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = CNT_W + INDEX_W;

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CMP_W-1:0]   w_idx_x;
    logic [CMP_W-1:0]   w_cnt_x;
    logic [INDEX_W-1:0] w_cnt_pos;
    logic [INDEX_W-1:0] w_last_pos;
    logic [INDEX_W-1:0] w_idx_pos;
    logic               w_indexed;
    logic               w_bad_idx;
    logic               w_full;
    logic               w_empty;
    t_op                w_op;
    logic               w_rd;
    logic [INDEX_W-1:0] w_pos;
    t_status            w_status;

    assign w_idx_x    = CMP_W'(i_index);
    assign w_cnt_x    = CMP_W'(r_count);
    assign w_cnt_pos  = w_cnt_x[INDEX_W-1:0];
    assign w_last_pos = w_cnt_pos - INDEX_W'(1);
    assign w_idx_pos  = i_index - INDEX_W'(1);
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_indexed  = (i_action == ACT_INSERT_AT) || (i_action == ACT_REMOVE_AT)
                     || (i_action == ACT_GET_AT);
    assign w_bad_idx  = (i_index == '0) || (w_idx_x > w_cnt_x);

    always_comb begin
        w_op     = OP_NONE;
        w_rd     = 1'b0;
        w_pos    = '0;
        w_status = ST_OK;
        unique case (i_action)
            ACT_ADD_LAST:     w_pos = w_cnt_pos;
            ACT_ADD_FIRST:    w_pos = '0;
            ACT_INSERT_AT:    w_pos = w_idx_pos;
            ACT_REMOVE_FIRST: w_pos = '0;
            ACT_REMOVE_LAST:  w_pos = w_last_pos;
            ACT_REMOVE_AT:    w_pos = w_idx_pos;
            ACT_GET_FIRST:    w_pos = '0;
            ACT_GET_LAST:     w_pos = w_last_pos;
            ACT_GET_AT:       w_pos = w_idx_pos;
            default:          w_pos = '0;
        endcase
        priority if (w_indexed && w_bad_idx) begin
            w_status = ST_BAD_INDEX;
        end else if (i_action == ACT_ADD_LAST || i_action == ACT_ADD_FIRST
                     || i_action == ACT_INSERT_AT) begin
            if (w_full) begin
                w_status = ST_FULL;
            end else begin
                w_op = OP_INSERT;
            end
        end else if (i_action == ACT_REMOVE_FIRST || i_action == ACT_REMOVE_LAST
                     || i_action == ACT_REMOVE_AT) begin
            if (w_empty) begin
                w_status = ST_EMPTY;
            end else begin
                w_op = OP_REMOVE;
                w_rd = 1'b1;
            end
        end else if (i_action == ACT_GET_FIRST || i_action == ACT_GET_LAST
                     || i_action == ACT_GET_AT) begin
            if (w_empty) begin
                w_status = ST_EMPTY;
            end else begin
                w_rd = 1'b1;
            end
        end else begin
            w_status = ST_OK;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_fire) begin
            unique case (w_op)
                OP_INSERT: n_count = r_count + CNT_W'(1);
                OP_REMOVE: n_count = r_count - CNT_W'(1);
                default:   n_count = r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Cells only move on an accepted beat.
    assign o_cmd.op  = i_fire ? w_op : OP_NONE;
    assign o_cmd.rd  = w_rd;
    assign o_cmd.pos = w_pos;
    assign o_status  = w_status;
    assign o_count   = n_count;

endmodule
